// ===== hw/rtl/mtde_pkg.sv =====
// ----------------------------------------------------------------------------
// mtde_pkg
// Shared types, codes and helpers of the multi-timer deadline engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mtde_pkg;

  localparam int TimeW  = 64;
  localparam int StepW  = 32;
  localparam int SlotW  = 4;

  typedef enum logic [1:0] {
    MODE_ADVANCE = 2'd0,
    MODE_START   = 2'd1,
    MODE_STOP    = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_FIRE = 2'd1,
    KIND_NONE = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT,
    ST_FIRE
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic advance;     // add step to time, clear fire count
    logic arm;         // start a timer slot
    logic disarm;      // stop a timer slot
    logic set_ack;     // queue an acknowledge result
    logic scan_start;  // begin a pass over all slots
    logic set_none;    // queue a nothing-due result
    logic set_tail;    // finalize last/still_due of the queued fire result
    logic fire;        // fire the best slot of the last scan
    logic emit;        // move the queued result to the output register
  } mtde_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_done;
    logic found;
    logic fire_zero;
    logic out_free;
    logic pend_last;
  } mtde_sts_t;

  // Saturating add of a 32-bit amount to a 64-bit time
  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [StepW-1:0] b);
    logic [TimeW:0] sum;
    sum = {1'b0, a} + {{(TimeW - StepW + 1){1'b0}}, b};
    return sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mtde_ctrl.sv =====
// ----------------------------------------------------------------------------
// mtde_ctrl
// Sequencer of the timer engine: decodes items, runs slot scans and fires,
// and hands results to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mtde_ctrl
  import mtde_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] mode_i,
  output logic            in_ready_o,
  input  wire mtde_sts_t  sts_i,
  output mtde_cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (mode_i)
            MODE_ADVANCE:         state_d = ST_SCAN;
            MODE_START, MODE_STOP: state_d = ST_EMIT;
            default:              state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_done) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts_i.fire_zero && sts_i.found) state_d = ST_FIRE;
        else                                state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) state_d = sts_i.pend_last ? ST_IDLE : ST_FIRE;
      end
      ST_FIRE: state_d = ST_SCAN;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (mode_i)
            MODE_ADVANCE: begin
              cmd_o.advance    = 1'b1;
              cmd_o.scan_start = 1'b1;
            end
            MODE_START: begin
              cmd_o.arm     = 1'b1;
              cmd_o.set_ack = 1'b1;
            end
            MODE_STOP: begin
              cmd_o.disarm  = 1'b1;
              cmd_o.set_ack = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_DECIDE: begin
        if (sts_i.fire_zero) begin
          cmd_o.set_none = !sts_i.found;
        end else begin
          cmd_o.set_tail = 1'b1;
        end
      end
      ST_EMIT: cmd_o.emit = sts_i.out_free;
      ST_FIRE: begin
        cmd_o.fire       = 1'b1;
        cmd_o.scan_start = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mtde_datapath.sv =====
// ----------------------------------------------------------------------------
// mtde_datapath
// Time counter, slot storage, earliest-deadline scan, queued result and
// output register of the timer engine.
// ----------------------------------------------------------------------------
`default_nettype none

module mtde_datapath
  import mtde_pkg::*;
#(
  parameter int TIMER_SLOTS = 16,
  parameter int MAX_FIRES   = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire mtde_cmd_t        cmd_i,
  output mtde_sts_t             sts_o,
  input  wire logic [SlotW-1:0] timer_slot_i,
  input  wire logic [StepW-1:0] time_step_i,
  input  wire logic [StepW-1:0] timeout_i,
  input  wire logic             repeat_req_i,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output logic [1:0]            kind_o,
  output logic [SlotW-1:0]      fired_slot_o,
  output logic [TimeW-1:0]      fire_deadline_o,
  output logic                  still_due_o,
  output logic                  last_o
);

  localparam int IdxW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CntW = $clog2(MAX_FIRES + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TIMER_SLOTS - 1);

  // Time and armed bits
  logic [TimeW-1:0]       time_q;
  logic [TIMER_SLOTS-1:0] armed_q;

  // Slot storage
  logic [TimeW-1:0] dl_mem  [TIMER_SLOTS];
  logic [StepW-1:0] per_mem [TIMER_SLOTS];
  logic             dl_we;
  logic [IdxW-1:0]  dl_waddr;
  logic [TimeW-1:0] dl_wdata;

  // Scan pipeline
  logic             iss_act_q;
  logic [IdxW-1:0]  iss_idx_q;
  logic             rd_vld_q;
  logic [IdxW-1:0]  rd_idx_q;
  logic [TimeW-1:0] rd_dl_q;
  logic [StepW-1:0] rd_per_q;
  logic             found_q;
  logic [IdxW-1:0]  best_idx_q;
  logic [TimeW-1:0] best_dl_q;
  logic [StepW-1:0] best_per_q;
  logic             due_c;
  logic             better_c;

  logic [CntW-1:0]  fire_cnt_q;
  logic             fire_max;

  // Queued result
  kind_e            pend_kind_q;
  logic [SlotW-1:0] pend_slot_q;
  logic [TimeW-1:0] pend_dl_q;
  logic             pend_due_q;
  logic             pend_last_q;

  // Output register
  logic             out_valid_q;
  kind_e            out_kind_q;
  logic [SlotW-1:0] out_slot_q;
  logic [TimeW-1:0] out_dl_q;
  logic             out_due_q;
  logic             out_last_q;
  logic             out_free;

  logic             slot_ok;
  logic [IdxW-1:0]  cmd_idx;

  assign slot_ok  = ({{(32 - SlotW){1'b0}}, timer_slot_i} < TIMER_SLOTS);
  assign cmd_idx  = IdxW'(timer_slot_i);
  assign fire_max = (fire_cnt_q == CntW'(MAX_FIRES));
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
    end else if (cmd_i.advance) begin
      time_q <= sat_add(time_q, time_step_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= '0;
    end else begin
      if (cmd_i.arm && slot_ok) armed_q[cmd_idx] <= 1'b1;
      if (cmd_i.disarm && slot_ok) armed_q[cmd_idx] <= 1'b0;
      // one-shot slots drop out when they fire
      if (cmd_i.fire && best_per_q == '0) armed_q[best_idx_q] <= 1'b0;
    end
  end

  always_comb begin
    dl_we    = 1'b0;
    dl_waddr = cmd_idx;
    dl_wdata = sat_add(time_q, timeout_i);
    if (cmd_i.arm && slot_ok) begin
      dl_we = 1'b1;
    end else if (cmd_i.fire && best_per_q != '0) begin
      dl_we    = 1'b1;
      dl_waddr = best_idx_q;
      dl_wdata = sat_add(best_dl_q, best_per_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (dl_we) dl_mem[dl_waddr] <= dl_wdata;
    if (cmd_i.arm && slot_ok) per_mem[cmd_idx] <= repeat_req_i ? timeout_i : '0;
    rd_dl_q  <= dl_mem[iss_idx_q];
    rd_per_q <= per_mem[iss_idx_q];
  end

  // Walk the slots one read per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_act_q <= 1'b0;
      iss_idx_q <= '0;
      rd_vld_q  <= 1'b0;
      rd_idx_q  <= '0;
    end else begin
      rd_vld_q <= iss_act_q;
      rd_idx_q <= iss_idx_q;
      if (cmd_i.scan_start) begin
        iss_act_q <= 1'b1;
        iss_idx_q <= '0;
      end else if (iss_act_q) begin
        if (iss_idx_q == LastIdx) begin
          iss_act_q <= 1'b0;
        end else begin
          iss_idx_q <= iss_idx_q + 1'b1;
        end
      end
    end
  end

  assign due_c    = rd_vld_q && armed_q[rd_idx_q] && (rd_dl_q <= time_q);
  assign better_c = !found_q || (rd_dl_q < best_dl_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.scan_start) begin
      found_q <= 1'b0;
    end else if (due_c) begin
      found_q <= 1'b1;
    end
  end

  // Strict compare keeps the lowest slot on equal deadlines
  always_ff @(posedge clk_i) begin
    if (due_c && better_c) begin
      best_idx_q <= rd_idx_q;
      best_dl_q  <= rd_dl_q;
      best_per_q <= rd_per_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fire_cnt_q <= '0;
    end else if (cmd_i.advance) begin
      fire_cnt_q <= '0;
    end else if (cmd_i.fire) begin
      fire_cnt_q <= fire_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_kind_q <= KIND_NONE;
      pend_last_q <= 1'b1;
      pend_slot_q <= '0;
      pend_dl_q   <= '0;
      pend_due_q  <= 1'b0;
    end else if (cmd_i.set_ack) begin
      pend_kind_q <= KIND_ACK;
      pend_slot_q <= timer_slot_i;
      pend_dl_q   <= '0;
      pend_due_q  <= 1'b0;
      pend_last_q <= 1'b1;
    end else if (cmd_i.set_none) begin
      pend_kind_q <= KIND_NONE;
      pend_slot_q <= '0;
      pend_dl_q   <= '0;
      pend_due_q  <= 1'b0;
      pend_last_q <= 1'b1;
    end else if (cmd_i.fire) begin
      pend_kind_q <= KIND_FIRE;
      pend_slot_q <= SlotW'(best_idx_q);
      pend_dl_q   <= best_dl_q;
      pend_due_q  <= 1'b0;
      pend_last_q <= 1'b0;
    end else if (cmd_i.set_tail) begin
      // another fire follows unless the limit is reached or nothing is due
      pend_last_q <= !(found_q && !fire_max);
      pend_due_q  <= found_q && fire_max;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_q <= pend_kind_q;
      out_slot_q <= pend_slot_q;
      out_dl_q   <= pend_dl_q;
      out_due_q  <= pend_due_q;
      out_last_q <= pend_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = out_kind_q;
  assign fired_slot_o    = out_slot_q;
  assign fire_deadline_o = out_dl_q;
  assign still_due_o     = out_due_q;
  assign last_o          = out_last_q;

  assign sts_o.scan_done = rd_vld_q && (rd_idx_q == LastIdx);
  assign sts_o.found     = found_q;
  assign sts_o.fire_zero = (fire_cnt_q == '0);
  assign sts_o.out_free  = out_free;
  assign sts_o.pend_last = pend_last_q;

  a_fire_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_cnt_q <= CntW'(MAX_FIRES))
    else $error("fire count beyond limit");

  a_fire_needs_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fire |-> found_q && !fire_max)
    else $error("fire without a due slot");

  a_fire_deadline_past: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && pend_kind_q == KIND_FIRE |-> pend_dl_q <= time_q)
    else $error("fired deadline ahead of time");

  a_one_shot_disarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fire && best_per_q == '0 |=> !armed_q[$past(best_idx_q)])
    else $error("one-shot slot still armed after firing");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("result overwrote a pending output");

endmodule

`default_nettype wire

// ===== hw/rtl/multi_timer_deadline_engine_top.sv =====
// ----------------------------------------------------------------------------
// multi_timer_deadline_engine_top
// Multi-slot one-shot and periodic deadline timer with a 64-bit time base.
// ----------------------------------------------------------------------------
// Items are handled one at a time. Start and stop queue an acknowledge that
// moves to the output register once it is free. An advance scans every slot
// through the single read port of the slot memory, once at first and again
// after each fired slot, and any stall on the output side can hold it.
// Each advance delivers at most MAX_FIRES fire results; results leave in
// earliest-deadline order, lowest slot first on equal deadlines.
`default_nettype none

module multi_timer_deadline_engine_top
  import mtde_pkg::*;
#(
  parameter int TIMER_SLOTS = 16,
  parameter int MAX_FIRES   = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       mode_i,
  input  wire logic [SlotW-1:0] timer_slot_i,
  input  wire logic [StepW-1:0] time_step_i,
  input  wire logic [StepW-1:0] timeout_i,
  input  wire logic             repeat_req_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [1:0]            kind_o,
  output logic [SlotW-1:0]      fired_slot_o,
  output logic [TimeW-1:0]      fire_deadline_o,
  output logic                  still_due_o,
  output logic                  last_o
);

  mtde_cmd_t cmd;
  mtde_sts_t sts;

  mtde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mtde_datapath #(
    .TIMER_SLOTS (TIMER_SLOTS),
    .MAX_FIRES   (MAX_FIRES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .timer_slot_i    (timer_slot_i),
    .time_step_i     (time_step_i),
    .timeout_i       (timeout_i),
    .repeat_req_i    (repeat_req_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .kind_o          (kind_o),
    .fired_slot_o    (fired_slot_o),
    .fire_deadline_o (fire_deadline_o),
    .still_due_o     (still_due_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

// ===== dv/tb_multi_timer_deadline_engine_top.sv =====
// ----------------------------------------------------------------------------
// tb_multi_timer_deadline_engine_top
// Self-checking bench for the multi-slot deadline timer engine. A command
// queue feeds a bursty driver; a stalling receiver and a monitor compare
// every result against a cycle-free timer model kept inside the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_multi_timer_deadline_engine_top
  import mtde_pkg::*;
();

  localparam int TIMER_SLOTS = 16;
  localparam int MAX_FIRES   = 64;
  localparam int CmdTarget   = 370;
  localparam int IdleLimit   = 4000;
  localparam int DrainCycles = 64;
  localparam logic [1:0] ModeUnused = 2'd3;

  typedef struct packed {
    logic [1:0]       mode;
    logic [SlotW-1:0] slot;
    logic [StepW-1:0] step;
    logic [StepW-1:0] tmo;
    logic             rep;
  } timer_cmd_t;

  typedef struct packed {
    kind_e            kind;
    logic [SlotW-1:0] slot;
    logic [TimeW-1:0] deadline;
    logic             still_due;
    logic             last;
  } timer_event_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_MOSTLY,
    RDY_PATTERN,
    RDY_SPARSE
  } rdy_mode_e;

  localparam logic [15:0] RdyPattern = 16'b1011_0011_1000_1110;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cmd_valid = 1'b0;
  timer_cmd_t       cmd_item = '0;
  logic             cmd_ready;
  logic             ev_valid;
  logic             ev_ready = 1'b0;
  logic [1:0]       kind_o;
  logic [SlotW-1:0] fired_slot_o;
  logic [TimeW-1:0] fire_deadline_o;
  logic             still_due_o;
  logic             last_o;

  multi_timer_deadline_engine_top #(
    .TIMER_SLOTS(TIMER_SLOTS),
    .MAX_FIRES  (MAX_FIRES)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (cmd_valid),
    .in_ready_o     (cmd_ready),
    .mode_i         (cmd_item.mode),
    .timer_slot_i   (cmd_item.slot),
    .time_step_i    (cmd_item.step),
    .timeout_i      (cmd_item.tmo),
    .repeat_req_i   (cmd_item.rep),
    .out_valid_o    (ev_valid),
    .out_ready_i    (ev_ready),
    .kind_o         (kind_o),
    .fired_slot_o   (fired_slot_o),
    .fire_deadline_o(fire_deadline_o),
    .still_due_o    (still_due_o),
    .last_o         (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Model state
  logic [TimeW-1:0] now_us;
  logic             slot_on [TIMER_SLOTS];
  logic [TimeW-1:0] slot_dl [TIMER_SLOTS];
  logic [StepW-1:0] slot_per[TIMER_SLOTS];

  timer_cmd_t   cmd_q[$];
  timer_event_t timer_events_q[$];

  int cmd_count;
  int err_count;
  int n_adv, n_start, n_stop, n_fire, n_ack, n_none, max_batch, capped_batches;
  int idle_cycles;

  function automatic logic [TimeW-1:0] add_clamped(input logic [TimeW-1:0] a,
                                                   input logic [StepW-1:0] b);
    logic [TimeW:0] sum;
    sum = {1'b0, a} + {{(TimeW - StepW + 1){1'b0}}, b};
    return sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];
  endfunction

  // Append to the tail of the queues
  task automatic expect_event(input timer_event_t e);
    timer_events_q.insert(timer_events_q.size(), e);
  endtask

  task automatic queue_cmd(input timer_cmd_t c);
    cmd_q.insert(cmd_q.size(), c);
  endtask

  // Earliest due deadline, lowest slot on ties; -1 when nothing is due
  function automatic int earliest_due();
    int best;
    best = -1;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      if (slot_on[i] && slot_dl[i] <= now_us &&
          (best < 0 || slot_dl[i] < slot_dl[best]))
        best = i;
    end
    return best;
  endfunction

  task automatic apply_timer_cmd(input timer_cmd_t c);
    timer_event_t ev;
    timer_event_t held;
    bit           have_held;
    int           n;
    int           s;
    have_held = 1'b0;
    n = 0;
    ev = '0;
    held = '0;
    case (c.mode)
      MODE_ADVANCE: begin
        n_adv++;
        now_us = add_clamped(now_us, c.step);
        while (n < MAX_FIRES) begin
          s = earliest_due();
          if (s < 0) break;
          // hold each fire back one step so the tail can be patched
          if (have_held) expect_event(held);
          held.kind      = KIND_FIRE;
          held.slot      = s[SlotW-1:0];
          held.deadline  = slot_dl[s];
          held.still_due = 1'b0;
          held.last      = 1'b0;
          have_held = 1'b1;
          if (slot_per[s] != '0) slot_dl[s] = add_clamped(slot_dl[s], slot_per[s]);
          else slot_on[s] = 1'b0;
          n++;
        end
        if (!have_held) begin
          ev.kind = KIND_NONE;
          ev.last = 1'b1;
          expect_event(ev);
          n_none++;
        end else begin
          held.still_due = (earliest_due() >= 0);
          held.last      = 1'b1;
          expect_event(held);
          n_fire += n;
          if (n > max_batch) max_batch = n;
          if (held.still_due) capped_batches++;
        end
      end
      MODE_START, MODE_STOP: begin
        if (c.mode == MODE_START) begin
          n_start++;
          slot_on[c.slot]  = 1'b1;
          slot_dl[c.slot]  = add_clamped(now_us, c.tmo);
          slot_per[c.slot] = c.rep ? c.tmo : '0;
        end else begin
          n_stop++;
          slot_on[c.slot] = 1'b0;
        end
        ev.kind = KIND_ACK;
        ev.slot = c.slot;
        ev.last = 1'b1;
        expect_event(ev);
        n_ack++;
      end
      default: ;  // unused mode: drop
    endcase
  endtask

  // Command builders; fields the mode does not use get random content
  task automatic push_start(input int slot, input logic [StepW-1:0] tmo, input logic rep);
    timer_cmd_t c;
    c.mode = MODE_START;
    c.slot = slot[SlotW-1:0];
    c.step = $urandom;
    c.tmo  = tmo;
    c.rep  = rep;
    queue_cmd(c);
    cmd_count++;
  endtask

  task automatic push_stop(input int slot);
    timer_cmd_t c;
    c.mode = MODE_STOP;
    c.slot = slot[SlotW-1:0];
    c.step = $urandom;
    c.tmo  = $urandom;
    c.rep  = 1'($urandom_range(0, 1));
    queue_cmd(c);
    cmd_count++;
  endtask

  task automatic push_advance(input logic [StepW-1:0] step);
    timer_cmd_t c;
    c.mode = MODE_ADVANCE;
    c.slot = SlotW'($urandom_range(0, TIMER_SLOTS - 1));
    c.step = step;
    c.tmo  = $urandom;
    c.rep  = 1'($urandom_range(0, 1));
    queue_cmd(c);
    cmd_count++;
  endtask

  task automatic push_noise();
    timer_cmd_t c;
    c.mode = ModeUnused;
    c.slot = SlotW'($urandom_range(0, TIMER_SLOTS - 1));
    c.step = $urandom;
    c.tmo  = $urandom;
    c.rep  = 1'($urandom_range(0, 1));
    queue_cmd(c);
  endtask

  // Several fast periodic slots, one advance and three zero advances: overrun the fire limit
  task automatic push_storm();
    int k;
    int base;
    k = $urandom_range(3, 6);
    base = $urandom_range(0, TIMER_SLOTS - 1);
    for (int i = 0; i < k; i++)
      push_start((base + i) % TIMER_SLOTS, $urandom_range(1, 3), 1'b1);
    push_advance($urandom_range(15, 30));
    for (int i = 0; i < 3; i++) push_advance('0);
    for (int i = 0; i < k; i++) push_stop((base + i) % TIMER_SLOTS);
  endtask

  // Clear every slot first so huge steps cannot leave an endless backlog
  task automatic push_big_jump();
    int a;
    int b;
    a = $urandom_range(0, TIMER_SLOTS - 1);
    b = $urandom_range(0, TIMER_SLOTS - 1);
    for (int i = 0; i < TIMER_SLOTS; i++) push_stop(i);
    push_start(a, $urandom | 32'h8000_0000, 1'($urandom_range(0, 1)));
    push_start(b, $urandom | 32'h8000_0000, 1'($urandom_range(0, 1)));
    push_advance($urandom);
    push_advance($urandom);
    push_stop(a);
    push_stop(b);
  endtask

  task automatic note_mismatch(input string what, input logic [TimeW-1:0] want,
                               input logic [TimeW-1:0] got);
    err_count++;
    if (err_count <= 40)
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
  endtask

  // Driver: bursts of transfers separated by random gaps
  int cmd_burst_left;
  int cmd_gap_left;
  bit cmd_busy;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid      <= 1'b0;
      cmd_item       <= '0;
      cmd_burst_left = 0;
      cmd_gap_left   = 0;
    end else begin
      cmd_busy = cmd_valid;
      if (cmd_valid && cmd_ready) begin
        apply_timer_cmd(cmd_item);
        cmd_busy = 1'b0;
      end
      if (!cmd_busy) begin
        if (cmd_gap_left > 0) begin
          cmd_gap_left--;
          cmd_valid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          cmd_item  <= cmd_q.pop_front();
          cmd_valid <= 1'b1;
          if (cmd_burst_left > 0) begin
            cmd_burst_left--;
          end else begin
            cmd_burst_left = $urandom_range(0, 15);
            cmd_gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: picks a stall style at random each time its 8-bit counter wraps
  rdy_mode_e  rdy_mode;
  logic [7:0] rdy_cnt;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_ready <= 1'b0;
      rdy_mode <= RDY_ALWAYS;
      rdy_cnt  <= '0;
    end else begin
      rdy_cnt <= rdy_cnt + 8'd1;
      if (rdy_cnt == 8'hFF) rdy_mode <= rdy_mode_e'($urandom_range(0, 3));
      case (rdy_mode)
        RDY_ALWAYS:  ev_ready <= 1'b1;
        RDY_MOSTLY:  ev_ready <= ($urandom_range(0, 3) != 0);
        RDY_PATTERN: ev_ready <= RdyPattern[rdy_cnt[3:0]];
        default:     ev_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Monitor
  timer_event_t want_ev;

  always @(posedge clk_i) begin
    if (rst_ni && ev_valid && ev_ready) begin
      if (timer_events_q.size() == 0) begin
        err_count++;
        $display("%0t ns: result with none expected, kind %0d slot %0d deadline 0x%0h",
                 $time, kind_o, fired_slot_o, fire_deadline_o);
      end else begin
        want_ev = timer_events_q.pop_front();
        if (kind_o !== want_ev.kind)
          note_mismatch("kind", TimeW'(want_ev.kind), TimeW'(kind_o));
        if (fired_slot_o !== want_ev.slot)
          note_mismatch("fired_slot", TimeW'(want_ev.slot), TimeW'(fired_slot_o));
        if (fire_deadline_o !== want_ev.deadline)
          note_mismatch("fire_deadline", want_ev.deadline, fire_deadline_o);
        if (still_due_o !== want_ev.still_due)
          note_mismatch("still_due", TimeW'(want_ev.still_due), TimeW'(still_due_o));
        if (last_o !== want_ev.last)
          note_mismatch("last", TimeW'(want_ev.last), TimeW'(last_o));
      end
    end
  end

  // Watchdog: count cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_valid && cmd_ready) || (ev_valid && ev_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int  pick;
    int  r;
    logic             rep;
    logic [StepW-1:0] tmo;
    bit  timed_out;

    timed_out = 1'b0;
    now_us = '0;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      slot_on[i]  = 1'b0;
      slot_dl[i]  = '0;
      slot_per[i] = '0;
    end

    // Directed: empty advance, zero timeout, ties, stops, fire limit, extremes
    push_advance('0);
    push_start(0, '0, 1'b1);
    push_advance('0);
    push_start(15, '1, 1'b1);
    push_start(3, 10, 1'b0);
    push_start(5, 10, 1'b1);
    push_start(1, 10, 1'b0);
    push_start(7, 5, 1'b0);
    push_advance(10);
    push_stop(5);
    push_stop(5);
    push_stop(9);
    push_noise();
    for (int i = 8; i < 12; i++) push_start(i, 1, 1'b1);
    push_advance(20);
    push_advance('0);
    for (int i = 8; i < 12; i++) push_stop(i);
    push_advance('1);
    push_stop(15);

    push_storm();
    push_big_jump();
    while (cmd_count < CmdTarget) begin
      pick = $urandom_range(0, 99);
      if (pick < 1) begin
        push_storm();
      end else if (pick < 2) begin
        push_big_jump();
      end else if (pick < 7) begin
        push_noise();
      end else if (pick < 45) begin
        r   = $urandom_range(0, 99);
        rep = 1'($urandom_range(0, 1));
        if (r < 15) tmo = '0;
        else if (r < 25) tmo = $urandom | 32'h8000_0000;
        else if (rep) tmo = $urandom_range(20, 400);
        else tmo = $urandom_range(1, 300);
        push_start($urandom_range(0, TIMER_SLOTS - 1), tmo, rep);
      end else if (pick < 62) begin
        push_stop($urandom_range(0, TIMER_SLOTS - 1));
      end else begin
        push_advance(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 120));
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all commands sent and every expected result seen
    while (!(cmd_q.size() == 0 && !cmd_valid && timer_events_q.size() == 0)) begin
      @(posedge clk_i);
      if (idle_cycles >= IdleLimit) begin
        timed_out = 1'b1;
        break;
      end
    end

    if (timed_out) begin
      $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
               $time, IdleLimit, timer_events_q.size());
      $display("multi_timer_deadline_engine_top regression: fail");
    end else begin
      repeat (DrainCycles) @(posedge clk_i);
      $display("Covered %0d advances, %0d starts, %0d stops with bursty input and stalls",
               n_adv, n_start, n_stop);
      $display("Checked %0d fires, %0d acks, %0d empty advances; largest batch %0d, %0d capped",
               n_fire, n_ack, n_none, max_batch, capped_batches);
      if (err_count == 0) begin
        $display("multi_timer_deadline_engine_top regression: pass");
      end else begin
        $display("multi_timer_deadline_engine_top regression: fail");
      end
    end
    $finish;
  end

endmodule
